// ===== sv/rcdce_pkg.sv =====
package rcdce_pkg;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_PRESS   = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_AXIS    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CTL_UP       = 3'd0,
		CTL_DOWN     = 3'd1,
		CTL_LEFT     = 3'd2,
		CTL_RIGHT    = 3'd3,
		CTL_LIGHT    = 3'd4,
		CTL_BRAKE    = 3'd5,
		CTL_GEAR_FWD = 3'd6,
		CTL_GEAR_REV = 3'd7
	} control_t;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FACTOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_STEP   = 3'd4;

	// light modes
	localparam logic [1:0] LIGHT_OFF   = 2'd0;
	localparam logic [1:0] LIGHT_ON    = 2'd1;
	localparam logic [1:0] LIGHT_BRAKE = 2'd3;

	// held control bits
	localparam int HELD_UP    = 0;
	localparam int HELD_DOWN  = 1;
	localparam int HELD_LEFT  = 2;
	localparam int HELD_RIGHT = 3;
	localparam int HELD_BRAKE = 4;

	// arithmetic constants
	localparam logic [15:0] DEAD_ZONE  = 16'd3200;
	localparam logic [16:0] AXIS_FULL  = 17'd32767;
	localparam logic [7:0]  BRAKE_STEP = 8'd80;
	localparam logic [9:0]  CK_BIAS    = 10'h033;
	localparam logic [9:0]  CK_MAX     = 10'd255;
	localparam logic signed [10:0] WHEEL_MAX = 11'sd255;

	// frame layout
	localparam int FRAME_LEN = 12;
	localparam int FRAME_CNT_W = 4;
	localparam logic [FRAME_CNT_W-1:0] FRAME_LAST_IDX = 4'd11;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_TWO  = 8'h32;
	localparam logic [7:0] CH_P    = 8'h70;
	localparam logic [7:0] CH_A    = 8'h61;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) c = CH_ZERO + {4'd0, n};
		else c = CH_A + {4'd0, n - 4'd10};
		return c;
	endfunction

endpackage

// ===== sv/rcdce_if.sv =====
interface rcdce_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [2:0]         control;
	logic               axis_vertical;
	logic signed [15:0] axis_value;

	modport source (output valid, action, control, axis_vertical, axis_value, input ready);
	modport sink   (input valid, action, control, axis_vertical, axis_value, output ready);
endinterface

interface rcdce_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_char;
	logic       frame_last;

	modport source (output valid, frame_char, frame_last, input ready);
	modport sink   (input valid, frame_char, frame_last, output ready);
endinterface

// ===== sv/rc_car_drive_command_encoder_top.sv =====
// drive command encoder for a remote-controlled car. requests on cmd are press, release and
// axis events, which update speed, wheel, gear, lights and held controls in one registered
// pass and give no output, and ticks, which run brake, speed ramp, steering and clamps in the
// same single registered pass and queue a twelve-character lowercase-hex frame
// "0p" CC WW SS "20" KK. frames leave on the frame channel one character per cycle while
// frame.ready is high, so that serializer sets the sustained tick rate. one finished frame
// can wait behind the one being sent; events keep flowing while a frame drains, but once a
// second frame is waiting every request stalls until that frame moves to the serializer.
// the user must write configuration registers (top speed, axis inversion, accel factor, steer
// step) through cfg_we/cfg_index/cfg_data while the block is idle; the block does not enforce it.
module rc_car_drive_command_encoder_top (
	input  logic                             clk,
	input  logic                             arst_n,
	rcdce_cmd_if.sink                        cmd,
	rcdce_frame_if.source                    frame,
	input  logic                             cfg_we,
	input  logic [rcdce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcdce_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rcdce_pkg::*;

	// configuration registers
	logic [7:0] top_speed_q, accel_factor_q, steer_step_q;
	logic       invert_x_q, invert_y_q;

	// vehicle state
	logic [7:0]        speed_q;
	logic signed [8:0] wheel_q;
	logic [1:0]        light_q;
	logic              fwd_q;
	logic [4:0]        held_q;

	// next state
	logic [7:0]        speed_d;
	logic signed [8:0] wheel_d;
	logic [1:0]        light_d;
	logic              fwd_d;
	logic [4:0]        held_d;

	// handshake
	logic in_fire, tick_fire, out_fire, out_free, load_out;
	action_t  act;
	control_t ctl;

	// pending frame and output shifter
	logic                   pend_valid_q;
	logic [8*FRAME_LEN-1:0] pend_q, frame_new, shift_q;
	logic                   out_valid_q;
	logic [FRAME_CNT_W-1:0] out_cnt_q;

	// axis scaling
	logic        av_neg, av_dead;
	logic [15:0] av_mag;
	logic [23:0] av_prod;
	logic [8:0]  av_q0;
	logic [16:0] av_rem;
	logic [7:0]  av_scaled;

	// tick datapath
	logic [7:0]         spd_brk;
	logic [8:0]         room;
	logic [16:0]        ramp_prod;
	logic [9:0]         inc;
	logic signed [10:0] spd_raw, whl_raw;
	logic [7:0]         spd_new, wmag;
	logic signed [8:0]  whl_new;
	logic [1:0]         light_tick;
	logic [3:0]         ctrl;
	logic [9:0]         ck_sum;
	logic [7:0]         ck;

	assign act = action_t'(cmd.action);
	assign ctl = control_t'(cmd.control);

	assign out_fire  = out_valid_q && frame.ready;
	assign out_free  = !out_valid_q || (out_fire && out_cnt_q == FRAME_LAST_IDX);
	assign load_out  = out_free && pend_valid_q;
	assign cmd.ready = !pend_valid_q || load_out;
	assign in_fire   = cmd.valid && cmd.ready;
	assign tick_fire = in_fire && act == ACT_TICK;

	assign frame.valid      = out_valid_q;
	assign frame.frame_char = shift_q[8*FRAME_LEN-1 -: 8];
	assign frame.frame_last = out_cnt_q == FRAME_LAST_IDX;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_speed_q    <= 8'd255;
			invert_x_q     <= 1'b0;
			invert_y_q     <= 1'b0;
			accel_factor_q <= 8'd16;
			steer_step_q   <= 8'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOP_SPEED:    top_speed_q    <= cfg_data;
				REG_INVERT_X:     invert_x_q     <= cfg_data[0];
				REG_INVERT_Y:     invert_y_q     <= cfg_data[0];
				REG_ACCEL_FACTOR: accel_factor_q <= cfg_data;
				REG_STEER_STEP:   steer_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// axis scaling: |v|*255/32767 truncated; divide by 32767 as >>15 plus one correction
	always_comb begin
		av_neg    = cmd.axis_value[15];
		av_mag    = av_neg ? 16'(-cmd.axis_value) : cmd.axis_value;
		av_dead   = av_mag <= DEAD_ZONE;
		av_prod   = {av_mag, 8'd0} - {8'd0, av_mag};
		av_q0     = av_prod[23:15];
		av_rem    = {2'd0, av_prod[14:0]} + {8'd0, av_q0};
		av_scaled = (av_rem >= AXIS_FULL) ? 8'(av_q0 + 9'd1) : av_q0[7:0];
	end

	// tick: brake, ramp, steer, clamp, then build the frame
	always_comb begin
		if (held_q[HELD_BRAKE]) spd_brk = (speed_q > BRAKE_STEP) ? speed_q - BRAKE_STEP : 8'd0;
		else spd_brk = speed_q;
		room      = 9'd256 - {1'b0, spd_brk};
		ramp_prod = {9'd0, accel_factor_q} * {8'd0, room};
		inc       = {1'b0, ramp_prod[16:8]} + 10'd1;

		if (held_q[HELD_UP]) spd_raw = $signed({3'd0, spd_brk}) + $signed({1'b0, inc});
		else if (held_q[HELD_DOWN]) spd_raw = $signed({3'd0, spd_brk}) - $signed({1'b0, inc});
		else spd_raw = $signed({3'd0, spd_brk});

		if (spd_raw < 0) spd_new = 8'd0;
		else if (spd_raw > $signed({3'd0, top_speed_q})) spd_new = top_speed_q;
		else spd_new = spd_raw[7:0];

		if (held_q[HELD_LEFT]) whl_raw = 11'(wheel_q) - $signed({3'd0, steer_step_q});
		else if (held_q[HELD_RIGHT]) whl_raw = 11'(wheel_q) + $signed({3'd0, steer_step_q});
		else whl_raw = 11'(wheel_q);

		if (whl_raw > WHEEL_MAX) whl_new = 9'sd255;
		else if (whl_raw < -WHEEL_MAX) whl_new = -9'sd255;
		else whl_new = whl_raw[8:0];

		wmag       = whl_new[8] ? 8'(-whl_new) : whl_new[7:0];
		light_tick = held_q[HELD_BRAKE] ? LIGHT_BRAKE : light_q;

		// control byte: direction lamp bits, then steering bits
		if (spd_new != 8'd0) ctrl = fwd_q ? 4'd4 : 4'd8;
		else if (light_tick == LIGHT_ON) ctrl = 4'd4;
		else if (light_tick == LIGHT_BRAKE) ctrl = 4'd8;
		else ctrl = 4'd0;
		if (whl_new > 0) ctrl = ctrl | 4'd2;
		else if (whl_new < 0) ctrl = ctrl | 4'd1;

		// saturating checksum
		ck_sum = {2'd0, spd_new} + {2'd0, wmag} + CK_BIAS;
		ck     = (ck_sum > CK_MAX) ? 8'd255 : ck_sum[7:0];

		frame_new = {CH_ZERO, CH_P, CH_ZERO, hex_char(ctrl),
			hex_char(wmag[7:4]), hex_char(wmag[3:0]),
			hex_char(spd_new[7:4]), hex_char(spd_new[3:0]),
			CH_TWO, CH_ZERO, hex_char(ck[7:4]), hex_char(ck[3:0])};
	end

	// state update per request
	always_comb begin
		speed_d = speed_q;
		wheel_d = wheel_q;
		light_d = light_q;
		fwd_d   = fwd_q;
		held_d  = held_q;
		if (in_fire) begin
			case (act)
				ACT_TICK: begin
					speed_d = spd_new;
					wheel_d = whl_new;
					light_d = light_tick;
				end
				ACT_PRESS: begin
					case (ctl)
						CTL_UP: begin
							light_d = LIGHT_OFF;
							held_d[HELD_UP] = 1'b1;
						end
						CTL_DOWN: begin
							light_d = LIGHT_OFF;
							held_d[HELD_DOWN] = 1'b1;
						end
						CTL_LEFT:     held_d[HELD_LEFT] = 1'b1;
						CTL_RIGHT:    held_d[HELD_RIGHT] = 1'b1;
						CTL_LIGHT:    light_d = (light_q == LIGHT_OFF) ? LIGHT_ON : LIGHT_OFF;
						CTL_BRAKE:    held_d[HELD_BRAKE] = 1'b1;
						CTL_GEAR_FWD: if (speed_q == 8'd0) fwd_d = 1'b1;
						CTL_GEAR_REV: if (speed_q == 8'd0) fwd_d = 1'b0;
						default: ;
					endcase
				end
				ACT_RELEASE: begin
					case (ctl)
						CTL_UP:   held_d[HELD_UP] = 1'b0;
						CTL_DOWN: held_d[HELD_DOWN] = 1'b0;
						CTL_LEFT: begin
							held_d[HELD_LEFT] = 1'b0;
							wheel_d = 9'sd0;
						end
						CTL_RIGHT: begin
							held_d[HELD_RIGHT] = 1'b0;
							wheel_d = 9'sd0;
						end
						CTL_BRAKE: begin
							held_d[HELD_BRAKE] = 1'b0;
							if (light_q == LIGHT_BRAKE) light_d = LIGHT_OFF;
						end
						default: ;
					endcase
				end
				ACT_AXIS: begin
					if (!cmd.axis_vertical) begin
						if (av_dead) wheel_d = 9'sd0;
						else if (av_neg ^ invert_x_q) wheel_d = -$signed({1'b0, av_scaled});
						else wheel_d = $signed({1'b0, av_scaled});
					end else begin
						if (av_dead) speed_d = 8'd0;
						else begin
							// scaled value is never zero outside the dead zone
							speed_d = av_scaled;
							light_d = LIGHT_OFF;
							fwd_d   = av_neg ^ invert_y_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 8'd0;
			wheel_q <= 9'sd0;
			light_q <= LIGHT_OFF;
			fwd_q   <= 1'b1;
			held_q  <= 5'd0;
		end else begin
			speed_q <= speed_d;
			wheel_q <= wheel_d;
			light_q <= light_d;
			fwd_q   <= fwd_d;
			held_q  <= held_d;
		end
	end

	// pending frame slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_valid_q <= 1'b0;
		else if (tick_fire) pend_valid_q <= 1'b1;
		else if (load_out) pend_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (tick_fire) pend_q <= frame_new;
	end

	// character serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_cnt_q   <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			out_cnt_q   <= '0;
		end else if (out_fire) begin
			if (out_cnt_q == FRAME_LAST_IDX) out_valid_q <= 1'b0;
			out_cnt_q <= out_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) shift_q <= pend_q;
		else if (out_fire) shift_q <= {shift_q[8*FRAME_LEN-9:0], 8'd0};
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_cnt_q <= FRAME_LAST_IDX)
		else $error("frame character counter out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_valid_q && !load_out) |-> !cmd.ready)
		else $error("pending frame would be overwritten");

	a_speed_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> speed_q <= $past(top_speed_q))
		else $error("speed above limit after tick");

	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		wheel_q != 9'h100)
		else $error("wheel position out of range");

endmodule
